// ===== hdl/rbsi_pkg.sv =====
// Package for the ray / box slab intersection pipeline: widths, types, stage indexes.
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_W   = COORD_WIDTH + FRAC_BITS;
  localparam int DIV_LAT = COORD_WIDTH;
  localparam int T_W     = COORD_WIDTH + 1;

  localparam int IN_W    = 12 * COORD_WIDTH;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 1 + 3 * COORD_WIDTH;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  localparam int IDX_T   = DIV_LAT + 2;
  localparam int IDX_M   = DIV_LAT + 3;
  localparam int IDX_C   = DIV_LAT + 4;
  localparam int IDX_P   = DIV_LAT + 5;
  localparam int IDX_Q   = DIV_LAT + 6;
  localparam int N_STG   = DIV_LAT + 7;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [T_W-1:0]  dist_t;

  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] d;
    logic   [2:0] zero;
    logic   [2:0] neg_n;
    logic   [2:0] neg_f;
    logic         miss;
  } side_t;

endpackage

// ===== hdl/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rbsi_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rbsi_pkg::NUM_W-1:0]        num_i,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0]  den_i,
  output logic [rbsi_pkg::COORD_WIDTH-2:0]  quo_o,
  output logic                              over_o
);
  import rbsi_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int HI_W  = NUM_W - CW + 1;
  localparam int CMP_W = HI_W + CW;

  logic [CW-1:0] rem_q  [CW];
  logic [CW-1:0] den_q  [CW];
  logic [CW-2:0] low_q  [CW];
  logic [CW-2:0] quo_q  [CW];
  logic          over_q [CW];

  logic [CMP_W-1:0] hi_ext, den_ext;
  logic             over_d;

  always_comb begin
    hi_ext  = CMP_W'(num_i[NUM_W-1:CW-1]);
    den_ext = CMP_W'(den_i);
    over_d  = hi_ext >= den_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      over_q[0] <= over_d;
      rem_q[0]  <= over_d ? '0 : hi_ext[CW-1:0];
      den_q[0]  <= den_i;
      low_q[0]  <= num_i[CW-2:0];
      quo_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k < CW; k++) begin : g_stage
    localparam int B = CW - 1 - k;
    logic [CW:0] shf, dif;
    logic        ge;
    always_comb begin
      shf = {rem_q[k-1], low_q[k-1][B]};
      dif = shf - {1'b0, den_q[k-1]};
      ge  = shf >= {1'b0, den_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        over_q[k] <= over_q[k-1];
        rem_q[k]  <= ge ? dif[CW-1:0] : shf[CW-1:0];
        den_q[k]  <= den_q[k-1];
        low_q[k]  <= low_q[k-1];
        quo_q[k]  <= quo_q[k-1] | ((CW-1)'(ge) << B);
      end
    end
  end

  assign quo_o  = quo_q[CW-1];
  assign over_o = over_q[CW-1];

endmodule

// ===== hdl/rbsi_point.sv =====
// Point along the ray on one axis: multiply, scale, add to origin, saturate; origin if d = 0, zero on a miss.
module rbsi_point (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic                                    hit_i,
  input  logic [rbsi_pkg::COORD_WIDTH-2:0]        tmag_i,
  input  logic                                    tneg_i,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0]        o_i,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0]        d_i,
  output logic [rbsi_pkg::COORD_WIDTH-1:0]        point_o
);
  import rbsi_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int PROD_W = 2 * CW - 1;
  localparam int R_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W  = R_W + 2;
  localparam int HB_W   = SUM_W - CW + 1;

  logic [CW-1:0]     dmag;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic              sgn_q, zero_q, hit_q;
  coord_t            o_q;

  logic signed [SUM_W-1:0] o_ext, r_ext, v;
  logic [HB_W-1:0]         hb;
  coord_t                  sat, point_d, point_q;

  always_comb begin
    dmag   = d_i[CW-1] ? (~d_i + 1'b1) : d_i;
    prod_d = PROD_W'(tmag_i) * PROD_W'(dmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sgn_q  <= tneg_i ^ d_i[CW-1];
      zero_q <= d_i == '0;
      hit_q  <= hit_i;
      o_q    <= o_i;
    end
  end

  always_comb begin
    o_ext = SUM_W'($signed(o_q));
    r_ext = $signed(SUM_W'(prod_q[PROD_W-1:FRAC_BITS]));
    v     = sgn_q ? (o_ext - r_ext) : (o_ext + r_ext);
    hb    = v[SUM_W-1:CW-1];
    if (hb == '0 || hb == '1) begin
      sat = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end
    if (!hit_q) begin
      point_d = '0;
    end else if (zero_q) begin
      point_d = o_q;
    end else begin
      point_d = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// Ray / axis-aligned box slab intersection, streaming top level.
// Accepts one ray-box pair per cycle while not stalled and returns one result per pair, in order.
// The pipeline depth is set by the six slab dividers, which resolve one quotient
// bit per pipeline stage. The whole pipeline advances together; it holds only
// while a result sits unclaimed on the output. A miss returns hit = 0 with a zero
// point; a hit returns the entry point, or the exit point when the origin lies
// inside the box. All values Q16.16.
module ray_box_slab_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z
  input  logic [rbsi_pkg::IN_TW-1:0]    s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // hit, point_x, point_y, point_z, zero fill
  output logic [rbsi_pkg::OUT_TW-1:0]   m_tdata_o
);
  import rbsi_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic en;
  logic [N_STG-1:0] v_q;
  logic [IN_W-1:0]  in_q;

  assign en         = !v_q[IDX_Q] || m_tready_i;
  assign s_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N_STG-2:0], s_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= s_tdata_i[IN_W-1:0];
    end
  end

  // prep: plane selection, distances to planes, magnitudes
  coord_t [2:0] mag_n_d, mag_f_d, den_d;
  coord_t [2:0] mag_n_q, mag_f_q, den_q;
  side_t        side_d;
  side_t        side_q [DIV_LAT+1];

  always_comb begin
    side_d.miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      coord_t o, d, lo, hi, nr, fr;
      logic [CW:0] dn, df;
      o  = in_q[a*CW +: CW];
      d  = in_q[(3+a)*CW +: CW];
      lo = in_q[(6+a)*CW +: CW];
      hi = in_q[(9+a)*CW +: CW];
      nr = d[CW-1] ? hi : lo;
      fr = d[CW-1] ? lo : hi;
      dn = {nr[CW-1], nr} - {o[CW-1], o};
      df = {fr[CW-1], fr} - {o[CW-1], o};
      mag_n_d[a] = dn[CW] ? CW'(~dn + 1'b1) : dn[CW-1:0];
      mag_f_d[a] = df[CW] ? CW'(~df + 1'b1) : df[CW-1:0];
      den_d[a]   = d[CW-1] ? (~d + 1'b1) : d;
      side_d.o[a]     = o;
      side_d.d[a]     = d;
      side_d.zero[a]  = d == '0;
      side_d.neg_n[a] = dn[CW] ^ d[CW-1];
      side_d.neg_f[a] = df[CW] ^ d[CW-1];
      if (d == '0 && !($signed(lo) <= $signed(o) && $signed(o) <= $signed(hi))) begin
        side_d.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_n_q   <= mag_n_d;
      mag_f_q   <= mag_f_d;
      den_q     <= den_d;
      side_q[0] <= side_d;
    end
  end

  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic [CW-2:0] qn [3];
  logic [CW-2:0] qf [3];
  logic [2:0]    ovn, ovf;

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbsi_div u_div_n (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  ({mag_n_q[a], {FRAC_BITS{1'b0}}}),
      .den_i  (den_q[a]),
      .quo_o  (qn[a]),
      .over_o (ovn[a])
    );
    rbsi_div u_div_f (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  ({mag_f_q[a], {FRAC_BITS{1'b0}}}),
      .den_i  (den_q[a]),
      .quo_o  (qf[a]),
      .over_o (ovf[a])
    );
  end

  // signed entry and exit distances
  localparam dist_t UNB = dist_t'(1) <<< (CW - 1);
  dist_t tn_d [3];
  dist_t tf_d [3];
  dist_t tn_q [3];
  dist_t tf_q [3];
  side_t side_t_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [CW-2:0] mn, mf;
      mn = ovn[a] ? '1 : qn[a];
      mf = ovf[a] ? '1 : qf[a];
      if (side_q[DIV_LAT].zero[a]) begin
        tn_d[a] = -UNB;
        tf_d[a] = UNB;
      end else begin
        tn_d[a] = side_q[DIV_LAT].neg_n[a] ? -$signed({2'b00, mn}) : $signed({2'b00, mn});
        tf_d[a] = side_q[DIV_LAT].neg_f[a] ? -$signed({2'b00, mf}) : $signed({2'b00, mf});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tn_q     <= tn_d;
      tf_q     <= tf_d;
      side_t_q <= side_q[DIV_LAT];
    end
  end

  // interval intersection
  dist_t tmin_d, tmax_d, tmin_q, tmax_q;
  side_t side_m_q;

  always_comb begin
    tmin_d = tn_q[0];
    tmax_d = tf_q[0];
    for (int a = 1; a < 3; a++) begin
      if (tn_q[a] > tmin_d) tmin_d = tn_q[a];
      if (tf_q[a] < tmax_d) tmax_d = tf_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tmin_q   <= tmin_d;
      tmax_q   <= tmax_d;
      side_m_q <= side_t_q;
    end
  end

  // hit decision and distance choice
  logic          hit_c_d, hit_c_q, tneg_c_q, hit_p_q, hit_out_q;
  dist_t         tsel;
  dist_t         tabs;
  logic [CW-2:0] tmag_c_q;
  side_t         side_c_q;

  always_comb begin
    hit_c_d = !side_m_q.miss && !(tmin_q > tmax_q) && (tmax_q > 0);
    tsel    = (tmin_q > 0) ? tmin_q : tmax_q;
    tabs    = tsel[T_W-1] ? -tsel : tsel;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_c_q   <= hit_c_d;
      tneg_c_q  <= tsel[T_W-1];
      tmag_c_q  <= tabs[CW-2:0];
      side_c_q  <= side_m_q;
      hit_p_q   <= hit_c_q;
      hit_out_q <= hit_p_q;
    end
  end

  coord_t [2:0] point;

  for (genvar a = 0; a < 3; a++) begin : g_point
    rbsi_point u_point (
      .clk_i   (clk_i),
      .en_i    (en),
      .hit_i   (hit_c_q),
      .tmag_i  (tmag_c_q),
      .tneg_i  (tneg_c_q),
      .o_i     (side_c_q.o[a]),
      .d_i     (side_c_q.d[a]),
      .point_o (point[a])
    );
  end

  assign m_tvalid_o = v_q[IDX_Q];
  assign m_tdata_o  = OUT_TW'({point[2], point[1], point[0], hit_out_q});

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[0] |-> m_tdata_o[OUT_W-1:1] == '0)
    else $error("miss result carries a nonzero point");

  a_hit_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[IDX_C] && hit_c_q |-> !tneg_c_q)
    else $error("hit chosen at a distance behind the origin");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("pipeline stalled without a waiting result");

endmodule

// ===== tb/tb.sv =====
// Testbench for ray_box_slab_intersect: random and directed ray-box pairs vs a slab predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbsi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam longint UNB = 64'sd1 <<< 62;
  localparam longint CMAXV = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMINV = -(64'sd1 <<< (CW - 1));
  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [2:0][CW-1:0] hi;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] d;
    logic [2:0][CW-1:0] o;
  } ray_box_t;

  typedef struct packed {
    logic [CW-1:0] pz;
    logic [CW-1:0] py;
    logic [CW-1:0] px;
    logic          hit;
  } hit_res_t;

  logic clk_i, rst_ni;
  logic s_tvalid_i, s_tready_o, m_tvalid_o, m_tready_i;
  logic [IN_TW-1:0] s_tdata_i;
  logic [OUT_TW-1:0] m_tdata_o;

  ray_box_slab_intersect i_dut (.*);

  ray_box_t pending_rays[$];
  hit_res_t expected_hits[$];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0, out_gap = 0;
  bit stim_done = 0;
  bit hold_send = 0;
  bit in_acc = 0;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void add_ray(ray_box_t rb);
    pending_rays.insert(pending_rays.size(), rb);
  endfunction

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint umag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint plane_dist(longint p, longint o, longint d);
    longint diff;
    logic [127:0] num, q;
    logic [63:0] q64;
    diff = p - o;
    num = 128'(umag(diff)) << FB;
    q = num / 128'(umag(d));
    if (q > 128'(CMAXV)) q64 = CMAXV;
    else q64 = q[63:0];
    return ((diff < 0) != (d < 0)) ? -longint'(q64) : longint'(q64);
  endfunction

  function automatic longint walk(longint o, longint d, longint t);
    logic [127:0] prod;
    logic [127:0] r;
    longint v;
    if (d == 0) return o;
    prod = 128'(umag(t)) * 128'(umag(d));
    r = prod >> FB;
    if (r > 128'(UNB)) r = 128'(UNB);
    v = ((t < 0) != (d < 0)) ? o - longint'(r[63:0]) : o + longint'(r[63:0]);
    if (v > CMAXV) v = CMAXV;
    if (v < CMINV) v = CMINV;
    return v;
  endfunction

  function automatic hit_res_t predict_hit(ray_box_t rb);
    hit_res_t r;
    longint o[3], d[3], tn, tf, tmin, tmax, t, pt[3];
    bit ok;
    tmin = -UNB;
    tmax = UNB;
    ok = 1;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      o[a] = sx(rb.o[a]);
      d[a] = sx(rb.d[a]);
      if (d[a] == 0) begin
        tn = -UNB;
        tf = UNB;
        if (!(sx(rb.lo[a]) <= o[a] && o[a] <= sx(rb.hi[a]))) ok = 0;
      end else if (d[a] < 0) begin
        tn = plane_dist(sx(rb.hi[a]), o[a], d[a]);
        tf = plane_dist(sx(rb.lo[a]), o[a], d[a]);
      end else begin
        tn = plane_dist(sx(rb.lo[a]), o[a], d[a]);
        tf = plane_dist(sx(rb.hi[a]), o[a], d[a]);
      end
      if (tn > tmin) tmin = tn;
      if (tf < tmax) tmax = tf;
    end
    if (tmin > tmax || tmax <= 0) ok = 0;
    if (!ok) return r;
    t = tmin > 0 ? tmin : tmax;
    for (int a = 0; a < 3; a++) pt[a] = walk(o[a], d[a], t);
    r.hit = 1;
    r.px = pt[0][CW-1:0];
    r.py = pt[1][CW-1:0];
    r.pz = pt[2][CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [CW-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      2: return CW'($signed($urandom_range(0, 400)) - 200);
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return {1'b0, {(CW-1){1'b1}}};
          2: return {1'b1, {(CW-1){1'b0}}};
          3: return '1;
          default: return CW'(1);
        endcase
      end
    endcase
  endfunction

  function automatic ray_box_t rnd_ray(bit ordered);
    ray_box_t rb;
    logic [CW-1:0] a, b;
    int mode;
    mode = $urandom_range(0, 9);
    mode = mode < 2 ? 0 : (mode < 7 ? 1 : (mode < 9 ? 2 : 3));
    for (int i = 0; i < 3; i++) begin
      rb.o[i] = rnd_coord(mode);
      rb.d[i] = ($urandom_range(0, 7) == 0) ? '0 : rnd_coord(mode);
      a = rnd_coord(mode);
      b = rnd_coord(mode);
      if (ordered && $signed(a) > $signed(b)) begin
        rb.lo[i] = b;
        rb.hi[i] = a;
      end else begin
        rb.lo[i] = a;
        rb.hi[i] = b;
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t mk(longint ox, longint oy, longint oz, longint dx, longint dy,
                                  longint dz, longint l, longint h);
    ray_box_t rb;
    rb.o[0] = CW'(ox); rb.o[1] = CW'(oy); rb.o[2] = CW'(oz);
    rb.d[0] = CW'(dx); rb.d[1] = CW'(dy); rb.d[2] = CW'(dz);
    for (int i = 0; i < 3; i++) begin
      rb.lo[i] = CW'(l);
      rb.hi[i] = CW'(h);
    end
    return rb;
  endfunction

  initial begin
    longint u;
    u = 64'sd1 <<< FB;
    // hit from outside, from inside, behind, all-zero dir in and out
    add_ray(mk(-5*u, 0, 0, u, 0, 0, -u, u));
    add_ray(mk(0, 0, 0, u, u/2, -u, -u, u));
    add_ray(mk(5*u, 0, 0, u, 0, 0, -u, u));
    add_ray(mk(0, 0, 0, 0, 0, 0, -u, u));
    add_ray(mk(3*u, 0, 0, 0, 0, 0, -u, u));
    // zero dir axis with origin outside slab
    add_ray(mk(-5*u, 3*u, 0, u, 0, 0, -u, u));
    // grazing corner, exit exactly at origin
    add_ray(mk(-2*u, -2*u, 0, u, u, 0, -u, 0));
    add_ray(mk(u, 0, 0, u, 0, 0, -u, u));
    add_ray(mk(u, 0, 0, -u, 0, 0, -u, u));
    // unordered corners
    add_ray(mk(0, 0, 0, u, 0, 0, u, -u));
    add_ray(mk(0, 0, 0, 0, u, 0, u, -u));
    // saturating extremes
    add_ray(mk(CMINV, CMINV, CMINV, 1, 1, 1, CMAXV, CMAXV));
    add_ray(mk(CMINV, 0, 0, 1, 0, 0, CMAXV - 1, CMAXV));
    add_ray(mk(CMAXV, CMAXV, CMAXV, CMINV, CMINV, CMINV, CMINV, CMINV + 1));
    add_ray(mk(-1, -1, -1, CMAXV, CMINV, -1, CMINV, CMAXV));
    add_ray(mk(0, 0, 0, -1, -1, -1, CMINV, CMAXV));
    add_ray(mk(CMAXV, CMINV, 0, -1, 1, CMAXV, CMINV, CMAXV));
    for (int i = 0; i < 550; i++) begin
      add_ray(rnd_ray($urandom_range(0, 9) != 0));
      if (i == 275) begin
        wait (pending_rays.size() <= 1 || pending_rays.size() == 0);
      end
    end
    stim_done = 1;
  end

  // pause the sender once until all results are back
  initial begin
    wait (rst_ni);
    repeat (100) @(posedge clk_i);
    hold_send = 1;
    wait (expected_hits.size() == 0 && !s_tvalid_i);
    @(posedge clk_i);
    hold_send = 0;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 0;
      s_tdata_i <= '0;
      in_gap <= 0;
    end else if (s_tvalid_i && !in_acc) begin
    end else if (in_gap > 0) begin
      s_tvalid_i <= 0;
      in_gap <= in_gap - 1;
    end else if (pending_rays.size() > 0 && !hold_send) begin
      s_tvalid_i <= 1;
      s_tdata_i <= IN_TW'(pending_rays.pop_front());
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    end else begin
      s_tvalid_i <= 0;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      m_tready_i <= 0;
      out_gap <= out_gap - 1;
    end else begin
      m_tready_i <= 1;
      if (m_tvalid_o) out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    hit_res_t got, want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      in_acc <= s_tvalid_i && s_tready_o;
      if (s_tvalid_i && s_tready_o) begin
        expected_hits.insert(expected_hits.size(), predict_hit(ray_box_t'(s_tdata_i)));
      end
      if (m_tvalid_o && m_tready_i) begin
        got = hit_res_t'(m_tdata_o[OUT_W-1:0]);
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", longint'(got.hit), 0);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", longint'(got.hit), longint'(want.hit));
          if (got.px !== want.px)
            report_mismatch("point_x", longint'(got.px), longint'(want.px));
          if (got.py !== want.py)
            report_mismatch("point_y", longint'(got.py), longint'(want.py));
          if (got.pz !== want.pz)
            report_mismatch("point_z", longint'(got.pz), longint'(want.pz));
        end
      end
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    wait (stim_done && pending_rays.size() == 0);
    @(posedge clk_i);
    while (s_tvalid_i) @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (N_STG + 10) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/rbsi_pkg.sv
hdl/rbsi_div.sv
hdl/rbsi_point.sv
hdl/ray_box_slab_intersect.sv
tb/tb.sv
